// File: rtl/core/floor_ceiling_texel_caster_assert.svh
// ----------------------------------------------------------------------------
// Floor and ceiling texel caster assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef FLOOR_CEILING_TEXEL_CASTER_ASSERT_SVH
`define FLOOR_CEILING_TEXEL_CASTER_ASSERT_SVH

// Same-cycle implication
`define FCTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fctc assertion failed");

// Next-cycle implication
`define FCTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fctc assertion failed");

`endif

// File: rtl/core/fctc_pkg.sv
// ----------------------------------------------------------------------------
// fctc_pkg
// Types, register indexes and helpers of the floor and ceiling texel caster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fctc_pkg;

  localparam int unsigned TexSizeMax    = 1024;
  localparam int unsigned ScreenRowsMax = 2048;

  // configuration register indexes
  localparam logic [2:0] RegPlayerX    = 3'd0;
  localparam logic [2:0] RegPlayerY    = 3'd1;
  localparam logic [2:0] RegScreenH    = 3'd2;
  localparam logic [2:0] RegFloorTexW  = 3'd3;
  localparam logic [2:0] RegFloorTexH  = 3'd4;
  localparam logic [2:0] RegCeilTexW   = 3'd5;
  localparam logic [2:0] RegCeilTexH   = 3'd6;

  // payload carried alongside the divider
  typedef struct packed {
    logic [11:0]        column;
    logic [10:0]        row;
    logic               k_neg;
    logic               k_zero;
    logic               d_zero;
    logic               q_sat;
    logic               lh_sat;
    logic signed [25:0] ex;
    logic signed [25:0] ey;
  } fctc_pay_t;

  // clamp a texture size to the supported maximum
  function automatic logic [10:0] tex_size_sat(input logic [10:0] s);
    logic [10:0] r;
    r = (s > 11'(TexSizeMax)) ? 11'(TexSizeMax) : s;
    return r;
  endfunction

endpackage

// File: rtl/core/floor_ceiling_texel_caster.sv
// ----------------------------------------------------------------------------
// floor_ceiling_texel_caster
// Floor and ceiling texel lookup for a raycaster, one pixel per request.
// ----------------------------------------------------------------------------
// Takes a new request in every clock cycle (busy_o stays low) and returns one
// result per request, in request order, marked by done_o for one cycle; the
// receiver cannot stall it. Each request passes the two pipelined dividers: the
// floor weight quotient resolves one bit per stage over 31 stages, and the wall
// line-height quotient runs alongside it. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write it only while no
// request is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module floor_ceiling_texel_caster
  import fctc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               hit_side_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic [7:0]         cell_x_i,
  input  logic [7:0]         cell_y_i,
  input  logic [23:0]        wall_dist_i,
  input  logic [10:0]        row_i,
  input  logic [11:0]        column_i,
  output logic               done_o,
  output logic [11:0]        column_out_o,
  output logic               in_span_o,
  output logic [10:0]        floor_row_o,
  output logic [11:0]        ceil_row_o,
  output logic [9:0]         floor_u_o,
  output logic [9:0]         floor_v_o,
  output logic [9:0]         ceil_u_o,
  output logic [9:0]         ceil_v_o
);

  localparam int unsigned QuoW  = 31;
  localparam int unsigned LhW   = 13;
  localparam int unsigned DenW  = 36;
  localparam int unsigned LhDly = QuoW - LhW;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [23:0] px_q, py_q;
  logic [11:0] sh_q;
  logic [10:0] ftw_q, fth_q, ctw_q, cth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q  <= '0;
      py_q  <= '0;
      sh_q  <= 12'd480;
      ftw_q <= 11'd64;
      fth_q <= 11'd64;
      ctw_q <= 11'd64;
      cth_q <= 11'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPlayerX:   px_q  <= cfg_wdata_i;
        RegPlayerY:   py_q  <= cfg_wdata_i;
        RegScreenH:   sh_q  <= cfg_wdata_i[11:0];
        RegFloorTexW: ftw_q <= cfg_wdata_i[10:0];
        RegFloorTexH: fth_q <= cfg_wdata_i[10:0];
        RegCeilTexW:  ctw_q <= cfg_wdata_i[10:0];
        RegCeilTexH:  cth_q <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // clamp screen height and texture sizes
  logic [11:0] h;
  logic [10:0] s_fu, s_fv, s_cu, s_cv;

  assign h    = (sh_q > 12'(ScreenRowsMax)) ? 12'(ScreenRowsMax) : sh_q;
  assign s_fu = tex_size_sat(ftw_q);
  assign s_fv = tex_size_sat(fth_q);
  assign s_cu = tex_size_sat(ctw_q);
  assign s_cv = tex_size_sat(cth_q);

  assign busy_o = 1'b0;

  // --------------------------------------------------------------------------
  // stage a: capture request
  // --------------------------------------------------------------------------
  logic               vld_a_q;
  logic               side_a_q;
  logic signed [15:0] dx_a_q, dy_a_q;
  logic [7:0]         cx_a_q, cy_a_q;
  logic [23:0]        d_a_q;
  logic [10:0]        row_a_q;
  logic [11:0]        col_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    side_a_q <= hit_side_i;
    dx_a_q   <= dir_x_i;
    dy_a_q   <= dir_y_i;
    cx_a_q   <= cell_x_i;
    cy_a_q   <= cell_y_i;
    d_a_q    <= wall_dist_i;
    row_a_q  <= row_i;
    col_a_q  <= column_i;
  end

  // row offset from mid-screen
  logic signed [12:0] k_a;
  logic [11:0]        absk_a;
  logic signed [15:0] dsel_a;

  always_comb begin
    k_a    = $signed({1'b0, row_a_q, 1'b0}) - $signed({1'b0, h});
    absk_a = k_a[12] ? 12'(-k_a) : k_a[11:0];
    dsel_a = side_a_q ? dx_a_q : dy_a_q;
  end

  // --------------------------------------------------------------------------
  // stage b: weight divisor and wall offset products
  // --------------------------------------------------------------------------
  logic               vld_b_q;
  logic [DenW-1:0]    den_b_q;
  logic signed [40:0] wprod_b_q;
  logic               side_b_q, dxpos_b_q, dxneg_b_q, dypos_b_q;
  logic [7:0]         cx_b_q, cy_b_q;
  logic [23:0]        d_b_q;
  logic [10:0]        row_b_q;
  logic [11:0]        col_b_q;
  logic               kneg_b_q, kzero_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    den_b_q   <= absk_a * d_a_q;
    wprod_b_q <= $signed({1'b0, d_a_q}) * dsel_a;
    side_b_q  <= side_a_q;
    dxpos_b_q <= !dx_a_q[15] && (dx_a_q != '0);
    dxneg_b_q <= dx_a_q[15];
    dypos_b_q <= !dy_a_q[15] && (dy_a_q != '0);
    cx_b_q    <= cx_a_q;
    cy_b_q    <= cy_a_q;
    d_b_q     <= d_a_q;
    row_b_q   <= row_a_q;
    col_b_q   <= col_a_q;
    kneg_b_q  <= k_a[12];
    kzero_b_q <= (k_a == '0);
  end

  // wall foot and offsets from the player; divider seeds
  logic [15:0]     frac_b;
  logic [24:0]     fxw_b, fyw_b;
  logic [DenW-1:0] qseed_b, lhseed_b;
  logic            qsat_b, lhsat_b;
  fctc_pay_t       pay_b;

  always_comb begin
    frac_b = (side_b_q ? px_q[15:0] : py_q[15:0]) + wprod_b_q[29:14];
    if (!side_b_q && dxpos_b_q) begin
      fxw_b = {1'b0, cx_b_q, 16'd0};
      fyw_b = {1'b0, cy_b_q, frac_b};
    end else if (!side_b_q && dxneg_b_q) begin
      fxw_b = {(9'({1'b0, cx_b_q}) + 9'd1), 16'd0};
      fyw_b = {1'b0, cy_b_q, frac_b};
    end else if (side_b_q && dypos_b_q) begin
      fxw_b = {1'b0, cx_b_q, frac_b};
      fyw_b = {1'b0, cy_b_q, 16'd0};
    end else begin
      fxw_b = {1'b0, cx_b_q, frac_b};
      fyw_b = {(9'({1'b0, cy_b_q}) + 9'd1), 16'd0};
    end
    qseed_b  = DenW'({h, 1'b0});
    qsat_b   = qseed_b >= den_b_q;
    lhseed_b = DenW'({h, 3'b000});
    lhsat_b  = lhseed_b >= DenW'(d_b_q);

    pay_b.column = col_b_q;
    pay_b.row    = row_b_q;
    pay_b.k_neg  = kneg_b_q;
    pay_b.k_zero = kzero_b_q;
    pay_b.d_zero = (d_b_q == '0);
    pay_b.q_sat  = qsat_b;
    pay_b.lh_sat = lhsat_b;
    pay_b.ex     = $signed({1'b0, fxw_b}) - $signed({2'b00, px_q});
    pay_b.ey     = $signed({1'b0, fyw_b}) - $signed({2'b00, py_q});
  end

  // --------------------------------------------------------------------------
  // dividers: weight quotient and line height
  // --------------------------------------------------------------------------
  logic            qvld;
  logic [QuoW-1:0] qquo;
  logic            lhvld;
  logic [LhW-1:0]  lhquo;

  fctc_div_pipe #(
    .DEN_W (DenW),
    .QUO_W (QuoW)
  ) u_wdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_b_q),
    .den_i   (den_b_q),
    .rem_i   (qsat_b ? '0 : qseed_b),
    .valid_o (qvld),
    .quo_o   (qquo)
  );

  fctc_div_pipe #(
    .DEN_W (24),
    .QUO_W (LhW)
  ) u_lhdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_b_q),
    .den_i   (d_b_q),
    .rem_i   (lhsat_b ? 24'd0 : lhseed_b[23:0]),
    .valid_o (lhvld),
    .quo_o   (lhquo)
  );

  // delay payload and line height to match the weight divider
  fctc_pay_t      pay_q   [QuoW];
  logic [LhW-1:0] lhdly_q [LhDly];

  always_ff @(posedge clk_i) begin
    pay_q[0]   <= pay_b;
    lhdly_q[0] <= lhquo;
    for (int i = 1; i < QuoW; i++) begin
      pay_q[i] <= pay_q[i-1];
    end
    for (int i = 1; i < LhDly; i++) begin
      lhdly_q[i] <= lhdly_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // stage w: signed weight and span test
  // --------------------------------------------------------------------------
  fctc_pay_t          pay_w;
  logic [QuoW-1:0]    wmag_w;
  logic signed [31:0] w_w;
  logic [LhW-1:0]     lh_w;
  logic [12:0]        end_w;
  logic               span_w;

  always_comb begin
    pay_w  = pay_q[QuoW-1];
    wmag_w = pay_w.q_sat ? '1 : qquo;
    w_w    = pay_w.k_neg ? -$signed({1'b0, wmag_w}) : $signed({1'b0, wmag_w});
    lh_w   = pay_w.lh_sat ? '1 : lhdly_q[LhDly-1];
    end_w  = {1'b0, lh_w[LhW-1:1]} + {2'b00, h[11:1]};
    if (end_w >= {1'b0, h}) begin
      end_w = {1'b0, h} - 13'd1;
    end
    span_w = (h != '0) && !pay_w.d_zero && !pay_w.k_zero
          && ({2'b00, pay_w.row} >= end_w) && ({1'b0, pay_w.row} < h);
  end

  logic               vld_w_q, span_w_q;
  logic signed [31:0] w_w_q;
  logic signed [25:0] ex_w_q, ey_w_q;
  logic [11:0]        col_w_q, crow_w_q;
  logic [10:0]        row_w_q;

  // the line-height valid runs ahead; the weight valid marks the aligned item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_w_q <= 1'b0;
    end else begin
      vld_w_q <= qvld;
    end
  end

  always_ff @(posedge clk_i) begin
    span_w_q <= span_w;
    w_w_q    <= w_w;
    ex_w_q   <= pay_w.ex;
    ey_w_q   <= pay_w.ey;
    col_w_q  <= pay_w.column;
    row_w_q  <= pay_w.row;
    crow_w_q <= h - {1'b0, pay_w.row};
  end

  // --------------------------------------------------------------------------
  // stage m: scale offsets by the weight
  // --------------------------------------------------------------------------
  logic               vld_m_q, span_m_q;
  logic signed [57:0] mx_m_q, my_m_q;
  logic [11:0]        col_m_q, crow_m_q;
  logic [10:0]        row_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_m_q <= 1'b0;
    end else begin
      vld_m_q <= vld_w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_m_q   <= w_w_q * ex_w_q;
    my_m_q   <= w_w_q * ey_w_q;
    span_m_q <= span_w_q;
    col_m_q  <= col_w_q;
    row_m_q  <= row_w_q;
    crow_m_q <= crow_w_q;
  end

  // --------------------------------------------------------------------------
  // stage f: floor point, keep sign and fractional magnitude
  // --------------------------------------------------------------------------
  logic signed [42:0] fx_f, fy_f;
  logic [15:0]        ex_f, ey_f;

  always_comb begin
    fx_f = $signed({19'd0, px_q}) + 43'(mx_m_q >>> 16);
    fy_f = $signed({19'd0, py_q}) + 43'(my_m_q >>> 16);
    ex_f = fx_f[42] ? 16'(-fx_f[15:0]) : fx_f[15:0];
    ey_f = fy_f[42] ? 16'(-fy_f[15:0]) : fy_f[15:0];
  end

  logic        vld_f_q, span_f_q, nx_f_q, ny_f_q;
  logic [15:0] ex_f_q, ey_f_q;
  logic [11:0] col_f_q, crow_f_q;
  logic [10:0] row_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
    end else begin
      vld_f_q <= vld_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_f_q   <= fx_f[42];
    ny_f_q   <= fy_f[42];
    ex_f_q   <= ex_f;
    ey_f_q   <= ey_f;
    span_f_q <= span_m_q;
    col_f_q  <= col_m_q;
    row_f_q  <= row_m_q;
    crow_f_q <= crow_m_q;
  end

  // --------------------------------------------------------------------------
  // stage t: scale fractions by texture sizes
  // --------------------------------------------------------------------------
  logic [26:0] pfu_t, pfv_t, pcu_t, pcv_t;

  always_comb begin
    pfu_t = ex_f_q * s_fu;
    pfv_t = ey_f_q * s_fv;
    pcu_t = ex_f_q * s_cu;
    pcv_t = ey_f_q * s_cv;
  end

  logic        vld_t_q, span_t_q, nx_t_q, ny_t_q;
  logic [10:0] ufu_t_q, ufv_t_q, ucu_t_q, ucv_t_q;
  logic [11:0] col_t_q, crow_t_q;
  logic [10:0] row_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_t_q <= 1'b0;
    end else begin
      vld_t_q <= vld_f_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ufu_t_q  <= pfu_t[26:16];
    ufv_t_q  <= pfv_t[26:16];
    ucu_t_q  <= pcu_t[26:16];
    ucv_t_q  <= pcv_t[26:16];
    nx_t_q   <= nx_f_q;
    ny_t_q   <= ny_f_q;
    span_t_q <= span_f_q;
    col_t_q  <= col_f_q;
    row_t_q  <= row_f_q;
    crow_t_q <= crow_f_q;
  end

  // --------------------------------------------------------------------------
  // stage o: wrap negative coordinates and drive results
  // --------------------------------------------------------------------------
  logic [10:0] ifu_o, ifv_o, icu_o, icv_o;

  always_comb begin
    ifu_o = (nx_t_q && ufu_t_q != '0) ? s_fu - ufu_t_q : ufu_t_q;
    ifv_o = (ny_t_q && ufv_t_q != '0) ? s_fv - ufv_t_q : ufv_t_q;
    icu_o = (nx_t_q && ucu_t_q != '0) ? s_cu - ucu_t_q : ucu_t_q;
    icv_o = (ny_t_q && ucv_t_q != '0) ? s_cv - ucv_t_q : ucv_t_q;
  end

  logic        done_q, span_q;
  logic [11:0] col_q, crow_q;
  logic [10:0] row_q;
  logic [9:0]  fu_q, fv_q, cu_q, cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      span_q <= 1'b0;
      col_q  <= '0;
      crow_q <= '0;
      row_q  <= '0;
      fu_q   <= '0;
      fv_q   <= '0;
      cu_q   <= '0;
      cv_q   <= '0;
    end else begin
      done_q <= vld_t_q;
      span_q <= vld_t_q && span_t_q;
      col_q  <= col_t_q;
      if (vld_t_q && span_t_q) begin
        crow_q <= crow_t_q;
        row_q  <= row_t_q;
        fu_q   <= ifu_o[9:0];
        fv_q   <= ifv_o[9:0];
        cu_q   <= icu_o[9:0];
        cv_q   <= icv_o[9:0];
      end else begin
        crow_q <= '0;
        row_q  <= '0;
        fu_q   <= '0;
        fv_q   <= '0;
        cu_q   <= '0;
        cv_q   <= '0;
      end
    end
  end

  assign done_o       = done_q;
  assign in_span_o    = span_q;
  assign column_out_o = col_q;
  assign floor_row_o  = row_q;
  assign ceil_row_o   = crow_q;
  assign floor_u_o    = fu_q;
  assign floor_v_o    = fv_q;
  assign ceil_u_o     = cu_q;
  assign ceil_v_o     = cv_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
`include "floor_ceiling_texel_caster_assert.svh"

  `FCTC_ASSERT_IMP(a_span_needs_done, in_span_o, done_o)
  `FCTC_ASSERT_IMP(a_off_span_zero, done_o && !in_span_o, (floor_u_o == '0) && (floor_v_o == '0) && (ceil_u_o == '0) && (ceil_v_o == '0) && (ceil_row_o == '0))
  `FCTC_ASSERT_IMP(a_dividers_aligned, qvld, $past(lhvld, LhDly))
  `FCTC_ASSERT_NXT(a_div_valid_match, qvld, vld_w_q)

endmodule

// File: rtl/core/fctc_div_pipe.sv
// ----------------------------------------------------------------------------
// fctc_div_pipe
// Pipelined restoring divider, one quotient bit per register stage. The
// starting remainder must lie below the divisor; zeros are shifted in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fctc_div_pipe #(
  parameter int unsigned DEN_W = 36,
  parameter int unsigned QUO_W = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o
);

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic             vld_q [QUO_W];

  logic [DEN_W-1:0] src_rem [QUO_W];
  logic [DEN_W-1:0] src_den [QUO_W];
  logic [QUO_W-1:0] src_quo [QUO_W];
  logic             src_vld [QUO_W];

  assign src_rem[0] = rem_i;
  assign src_den[0] = den_i;
  assign src_quo[0] = '0;
  assign src_vld[0] = valid_i;

  for (genvar i = 1; i < QUO_W; i++) begin : g_src
    assign src_rem[i] = rem_q[i-1];
    assign src_den[i] = den_q[i-1];
    assign src_quo[i] = quo_q[i-1];
    assign src_vld[i] = vld_q[i-1];
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W:0]   rem2;
    logic             ge;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem_d;

    // shift, compare and subtract
    always_comb begin
      rem2  = {src_rem[i], 1'b0};
      ge    = rem2 >= {1'b0, src_den[i]};
      diff  = rem2 - {1'b0, src_den[i]};
      rem_d = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= src_vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i] <= rem_d;
      den_q[i] <= src_den[i];
      quo_q[i] <= {src_quo[i][QUO_W-2:0], ge};
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Floor and ceiling texel caster testbench
// Drives corner cases and random bursts of requests under several register
// settings and checks every result against an independent texel predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fctc_pkg::*;

  typedef struct packed {
    logic               hit_side;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
    logic [23:0]        wall_dist;
    logic [10:0]        row;
    logic [11:0]        column;
  } pixel_req_t;

  typedef struct packed {
    logic [11:0] column_out;
    logic        in_span;
    logic [10:0] floor_row;
    logic [11:0] ceil_row;
    logic [9:0]  floor_u;
    logic [9:0]  floor_v;
    logic [9:0]  ceil_u;
    logic [9:0]  ceil_v;
  } texel_res_t;

  // Texel predictor and store of pending texel results
  class texel_scoreboard;
    longint     pos_x, pos_y, scr_h;
    longint     ftex_w, ftex_h, ctex_w, ctex_h;
    texel_res_t pending[$];
    int         errors;

    function new();
      pos_x = 0; pos_y = 0; scr_h = 480;
      ftex_w = 64; ftex_h = 64; ctex_w = 64; ctex_h = 64;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        RegPlayerX:   pos_x  = val;
        RegPlayerY:   pos_y  = val;
        RegScreenH:   scr_h  = val[11:0];
        RegFloorTexW: ftex_w = val[10:0];
        RegFloorTexH: ftex_h = val[10:0];
        RegCeilTexW:  ctex_w = val[10:0];
        RegCeilTexH:  ctex_h = val[10:0];
        default: ;
      endcase
    endfunction

    // Map a floor coordinate onto a texture of the given size
    function longint texel(longint c, longint size);
      longint s, t, r;
      if (size == 0) return 0;
      s = (size > TexSizeMax) ? TexSizeMax : size;
      t = c * s;
      t = (t >= 0) ? (t >>> 16) : -((-t) >>> 16);
      r = t % s;
      if (r < 0) r += s;
      return r;
    endfunction

    // Lower end of the wall on screen, rows from here down are floor
    function longint wall_end(longint h, longint d);
      longint e;
      if (h > ScreenRowsMax) h = ScreenRowsMax;
      if (h == 0 || d == 0) return 0;
      e = ((h << 16) / d) / 2 + h / 2;
      if (e >= h) e = h - 1;
      return e;
    endfunction

    function texel_res_t cast(pixel_req_t rq);
      texel_res_t r;
      longint h, d, row, k, ak, q, w, wall, frac, cx, cy, fxw, fyw, fx, fy, dx, dy;
      r = '0;
      r.column_out = rq.column;
      h = (scr_h > ScreenRowsMax) ? ScreenRowsMax : scr_h;
      d = rq.wall_dist;
      row = rq.row;
      dx = rq.dir_x;
      dy = rq.dir_y;
      cx = rq.cell_x;
      cy = rq.cell_y;
      if (d == 0 || h == 0) return r;
      if (row < wall_end(h, d) || row >= h) return r;
      k = 2 * row - h;
      if (k == 0) return r;
      wall = rq.hit_side ? pos_x + ((d * dx) >>> 14) : pos_y + ((d * dy) >>> 14);
      frac = wall & 64'hFFFF;
      if (!rq.hit_side && dx > 0) begin
        fxw = cx << 16;        fyw = (cy << 16) + frac;
      end else if (!rq.hit_side && dx < 0) begin
        fxw = (cx + 1) << 16;  fyw = (cy << 16) + frac;
      end else if (rq.hit_side && dy > 0) begin
        fxw = (cx << 16) + frac; fyw = cy << 16;
      end else begin
        fxw = (cx << 16) + frac; fyw = (cy + 1) << 16;
      end
      ak = (k < 0) ? -k : k;
      q = (h << 32) / (ak * d);
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      w = (k < 0) ? -q : q;
      fx = pos_x + ((w * (fxw - pos_x)) >>> 16);
      fy = pos_y + ((w * (fyw - pos_y)) >>> 16);
      r.in_span   = 1'b1;
      r.floor_row = row[10:0];
      r.ceil_row  = 12'(h - row);
      r.floor_u   = 10'(texel(fx, ftex_w));
      r.floor_v   = 10'(texel(fy, ftex_h));
      r.ceil_u    = 10'(texel(fx, ctex_w));
      r.ceil_v    = 10'(texel(fy, ctex_h));
      return r;
    endfunction

    function void note_request(pixel_req_t rq);
      pending.push_back(cast(rq));
    endfunction

    function void field(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(texel_res_t a);
      texel_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with none pending, expected none, actual %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      field("column_out", e.column_out, a.column_out);
      field("in_span", e.in_span, a.in_span);
      field("floor_row", e.floor_row, a.floor_row);
      field("ceil_row", e.ceil_row, a.ceil_row);
      field("floor_u", e.floor_u, a.floor_u);
      field("floor_v", e.floor_v, a.floor_v);
      field("ceil_u", e.ceil_u, a.ceil_u);
      field("ceil_v", e.ceil_v, a.ceil_v);
    endfunction
  endclass

  localparam int IdleLimit = 5000;
  localparam int Drain     = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [23:0]        cfg_wdata_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               hit_side_i = 1'b0;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic [7:0]         cell_x_i = '0;
  logic [7:0]         cell_y_i = '0;
  logic [23:0]        wall_dist_i = 24'd1;
  logic [10:0]        row_i = '0;
  logic [11:0]        column_i = '0;
  logic               done_o;
  logic [11:0]        column_out_o;
  logic               in_span_o;
  logic [10:0]        floor_row_o;
  logic [11:0]        ceil_row_o;
  logic [9:0]         floor_u_o, floor_v_o, ceil_u_o, ceil_v_o;

  texel_scoreboard sb = new();
  int idle_cycles = 0;

  floor_ceiling_texel_caster dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Check each result as it leaves the block
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({column_out_o, in_span_o, floor_row_o, ceil_row_o,
                       floor_u_o, floor_v_o, ceil_u_o, ceil_v_o});
  end

  // Watchdog: count cycles without any handshake
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("** floor_ceiling_texel_caster: FAILED **");
      $finish;
    end
  end

  task automatic send_request(pixel_req_t rq);
    start_i     <= 1'b1;
    hit_side_i  <= rq.hit_side;
    dir_x_i     <= rq.dir_x;
    dir_y_i     <= rq.dir_y;
    cell_x_i    <= rq.cell_x;
    cell_y_i    <= rq.cell_y;
    wall_dist_i <= rq.wall_dist;
    row_i       <= rq.row;
    column_i    <= rq.column;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(rq);
  endtask

  task automatic pause(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold until every pending result is back, then let the pipe settle
  task automatic wait_drained();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [23:0] px, logic [23:0] py, logic [11:0] h,
                            logic [10:0] fw, logic [10:0] fh, logic [10:0] cw,
                            logic [10:0] ch);
    logic [23:0] vals[7];
    vals = '{px, py, 24'(h), 24'(fw), 24'(fh), 24'(cw), 24'(ch)};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(3'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random request; well-formed ones land inside the floor span
  function automatic pixel_req_t rand_request(bit well_formed);
    pixel_req_t rq;
    longint h, e;
    rq = {$urandom, $urandom, $urandom};
    case ($urandom_range(3))
      0:       rq.wall_dist = 24'($urandom_range(24'hFFFF, 1));
      1:       rq.wall_dist = 24'($urandom_range(24'hFFFFFF, 1));
      default: rq.wall_dist = 24'($urandom_range(24'hFFFFFF, 24'h10000));
    endcase
    if ($urandom_range(15) == 0) rq.dir_x = '0;
    if ($urandom_range(15) == 0) rq.dir_y = '0;
    h = (sb.scr_h > ScreenRowsMax) ? ScreenRowsMax : sb.scr_h;
    if (well_formed && h > 0) begin
      e = sb.wall_end(h, rq.wall_dist);
      rq.row = 11'($urandom_range(h - 1, e));
    end
    return rq;
  endfunction

  task automatic random_part(int n, bit drain_midway);
    int left, burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(24, 1);
      for (int i = 0; i < burst && left > 0; i++, left--)
        send_request(rand_request($urandom_range(9) < 8));
      if (drain_midway && left < n / 2) begin
        wait_drained();
        drain_midway = 0;
      end else if ($urandom_range(3) != 0) begin
        pause($urandom_range(12, 1));
      end
    end
  endtask

  // Corner requests under the reset settings
  task automatic directed_part();
    pixel_req_t rq;
    for (int i = 0; i < 22; i++) begin
      rq = rand_request(1);
      case (i)
        0:  rq.wall_dist = '0;
        1:  begin rq.wall_dist = 24'd1; rq.row = 11'd479; end
        2:  begin rq.wall_dist = 24'hFFFFFF; rq.row = 11'd479; end
        3:  rq.row = 11'd0;
        4:  rq.row = 11'h7FF;
        5:  begin rq.wall_dist = 24'hFFFFFF; rq.row = 11'd240; end
        6:  begin rq.hit_side = 0; rq.dir_x = 16'sh7FFF; rq.dir_y = 16'sh7FFF; end
        7:  begin rq.hit_side = 0; rq.dir_x = -16'sh8000; rq.dir_y = -16'sh8000; end
        8:  begin rq.hit_side = 0; rq.dir_x = '0; end
        9:  begin rq.hit_side = 1; rq.dir_y = 16'sh7FFF; rq.dir_x = -16'sh8000; end
        10: begin rq.hit_side = 1; rq.dir_y = -16'sh8000; end
        11: begin rq.hit_side = 1; rq.dir_y = '0; end
        12: begin rq.cell_x = 8'd0; rq.cell_y = 8'd0; rq.column = 12'd0; end
        13: begin rq.cell_x = 8'hFF; rq.cell_y = 8'hFF; rq.column = 12'hFFF; end
        default: ;
      endcase
      send_request(rq);
    end
    pause(3);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_part();
    random_part(100, 0);
    wait_drained();

    // Walk through settings, extremes included
    write_regs(24'h0, 24'hFFFFFF, 12'd481, 11'd1, 11'd1024, 11'd0, 11'd2047);
    random_part(110, 1);
    wait_drained();
    write_regs(24'hFFFFFF, 24'h0, 12'd2048, 11'd1024, 11'd1, 11'd2047, 11'd0);
    random_part(110, 0);
    wait_drained();
    write_regs(24'($urandom), 24'($urandom), 12'hFFF, 11'd2047, 11'd2047, 11'd1, 11'd1);
    random_part(110, 0);
    wait_drained();
    write_regs(24'($urandom), 24'($urandom), 12'd2, 11'd64, 11'd64, 11'd64, 11'd64);
    random_part(40, 0);
    wait_drained();
    write_regs(24'($urandom), 24'($urandom), 12'd0, 11'd3, 11'd5, 11'd7, 11'd9);
    random_part(30, 0);
    wait_drained();
    for (int p = 0; p < 3; p++) begin
      write_regs(24'($urandom), 24'($urandom), 12'($urandom_range(2048, 3)),
                 11'($urandom_range(1024, 1)), 11'($urandom_range(1024, 1)),
                 11'($urandom_range(1024, 1)), 11'($urandom_range(1024, 1)));
      random_part(120, 0);
      wait_drained();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** floor_ceiling_texel_caster: PASSED **");
    end else begin
      $display("** floor_ceiling_texel_caster: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/fctc_pkg.sv
rtl/core/fctc_div_pipe.sv
rtl/core/floor_ceiling_texel_caster.sv
sim/tb.sv
